// ===== rtl/uhcr_pkg.sv =====
// uhcr_pkg: shared types, codes and constants of the UHCI register file.
// No dependencies; the input register, register file, result register and top level import this package.
package uhcr_pkg;

  localparam int unsigned PORT_COUNT_DEF = 2;
  localparam int unsigned MAX_PORTS      = 8;

  // transaction kinds
  typedef enum logic [2:0] {
    KIND_READ   = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_TICK   = 3'd2,
    KIND_ATTACH = 3'd3,
    KIND_DETACH = 3'd4,
    KIND_ERROR  = 3'd5
  } kind_e;

  // access sizes; any other code acts as long
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;

  // io window offsets
  localparam logic [4:0] OFF_CMD    = 5'h00;
  localparam logic [4:0] OFF_STS    = 5'h02;
  localparam logic [4:0] OFF_INTR   = 5'h04;
  localparam logic [4:0] OFF_FRNUM  = 5'h06;
  localparam logic [4:0] OFF_FLBASE = 5'h08;
  localparam logic [4:0] OFF_SOF    = 5'h0c;
  localparam logic [4:0] OFF_PORTSC = 5'h10;

  // command bits
  localparam int CMD_RS      = 0;
  localparam int CMD_HCRESET = 1;
  localparam int CMD_GRESET  = 2;
  localparam int CMD_EGSM    = 3;
  localparam int CMD_FGR     = 4;

  // status bits
  localparam int ST_USBINT = 0;
  localparam int ST_USBERR = 1;
  localparam int ST_RD     = 2;
  localparam int ST_HSERR  = 3;
  localparam int ST_HCPERR = 4;
  localparam int ST_HALTED = 5;

  // port status/control bits
  localparam int PC_CCS   = 0;
  localparam int PC_CSC   = 1;
  localparam int PC_EN    = 2;
  localparam int PC_ENC   = 3;
  localparam int PC_LSDA  = 8;
  localparam int PC_RESET = 9;

  localparam logic [15:0] PC_RESET_VAL = 16'h0080;
  localparam logic [15:0] PC_KEEP_MASK = 16'h01fb;
  localparam logic [15:0] PC_W1C_MASK  = 16'h000a;
  localparam logic [7:0]  SOF_RESET    = 8'd64;

  localparam logic [31:0] UNMAPPED_BYTE = 32'h0000_00ff;
  localparam logic [31:0] UNMAPPED_WORD = 32'h0000_ff7f;
  localparam logic [31:0] UNMAPPED_LONG = 32'hffff_ffff;

  // port messages
  localparam logic [1:0] MSG_NONE     = 2'd0;
  localparam logic [1:0] MSG_ATTACH   = 2'd1;
  localparam logic [1:0] MSG_DETACH   = 2'd2;
  localparam logic [1:0] MSG_REATTACH = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  access_size;
    logic [4:0]  offset;
    logic [31:0] wdata;
    logic        port;
    logic        low_speed;
    logic [1:0]  frame_ints;
    logic [1:0]  err_flags;
  } item_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq_level;
    logic [1:0]  reset_ports;
    logic [1:0]  port_msg;
    logic        frame_start;
    logic [31:0] frame_ptr;
  } result_t;

  function automatic logic irq_calc(logic [1:0] hint, logic [15:0] inten, logic [5:0] sts);
    irq_calc = (hint[0] && inten[2]) || (hint[1] && inten[3]) ||
               (sts[ST_USBERR] && inten[0]) || (sts[ST_RD] && inten[1]) ||
               sts[ST_HSERR] || sts[ST_HCPERR];
  endfunction

endpackage

// ===== rtl/uhcr_if.sv =====
// uhcr_in_if / uhcr_out_if: valid/ready channels of the UHCI register file.
// Standalone; field widths follow the transaction formats.
interface uhcr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  access_size;
  logic [4:0]  offset;
  logic [31:0] wdata;
  logic        port;
  logic        low_speed;
  logic [1:0]  frame_ints;
  logic [1:0]  err_flags;

  modport source (output valid, kind, access_size, offset, wdata, port, low_speed,
                  frame_ints, err_flags, input ready);
  modport sink   (input valid, kind, access_size, offset, wdata, port, low_speed,
                  frame_ints, err_flags, output ready);
endinterface

interface uhcr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rdata;
  logic        irq_level;
  logic [1:0]  reset_ports;
  logic [1:0]  port_msg;
  logic        frame_start;
  logic [31:0] frame_ptr;

  modport source (output valid, rdata, irq_level, reset_ports, port_msg, frame_start,
                  frame_ptr, input ready);
  modport sink   (input valid, rdata, irq_level, reset_ports, port_msg, frame_start,
                  frame_ptr, output ready);
endinterface

// ===== rtl/uhcr_in_reg.sv =====
// uhcr_in_reg: input register of the UHCI register file.
// Depends on uhcr_pkg and uhcr_in_if.
module uhcr_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  uhcr_in_if.sink         in_i,
  input  logic            take_i,
  output logic            valid_o,
  output uhcr_pkg::item_t item_o
);
  import uhcr_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign in_i.ready = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= '{kind: in_i.kind, access_size: in_i.access_size, offset: in_i.offset,
                  wdata: in_i.wdata, port: in_i.port, low_speed: in_i.low_speed,
                  frame_ints: in_i.frame_ints, err_flags: in_i.err_flags};
    end
  end

endmodule

// ===== rtl/uhcr_regfile.sv =====
// uhcr_regfile: architectural registers and the single-pass update logic.
// Depends on uhcr_pkg.
module uhcr_regfile #(
  parameter int unsigned PORT_COUNT = uhcr_pkg::PORT_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  uhcr_pkg::item_t   item_i,
  output uhcr_pkg::result_t res_o
);
  import uhcr_pkg::*;

  logic [15:0] cmd_q, cmd_d;
  logic [5:0]  sts_q, sts_d;
  logic [1:0]  hint_q, hint_d;
  logic [15:0] inten_q, inten_d;
  logic [10:0] frnum_q, frnum_d;
  logic [19:0] flbase_q, flbase_d;
  logic [7:0]  sof_q, sof_d;
  logic [15:0] pc_q [PORT_COUNT];
  logic [15:0] pc_d [PORT_COUNT];
  logic [PORT_COUNT-1:0] present_q, present_d;
  logic [PORT_COUNT-1:0] low_q, low_d;
  logic        running_q, running_d;
  logic        irq_q, irq_d;

  always_comb begin
    logic [15:0]          val;
    logic [15:0]          c;
    logic [MAX_PORTS-1:0] rst_mask;
    logic [1:0]           msg;
    logic [31:0]          rdata;
    logic                 fstart;
    logic [31:0]          faddr;
    logic                 upd;
    logic                 creset;

    cmd_d     = cmd_q;
    sts_d     = sts_q;
    hint_d    = hint_q;
    inten_d   = inten_q;
    frnum_d   = frnum_q;
    flbase_d  = flbase_q;
    sof_d     = sof_q;
    pc_d      = pc_q;
    present_d = present_q;
    low_d     = low_q;
    running_d = running_q;
    val       = item_i.wdata[15:0];
    c         = '0;
    rst_mask  = '0;
    msg       = MSG_NONE;
    rdata     = '0;
    fstart    = 1'b0;
    faddr     = '0;
    upd       = 1'b0;
    creset    = 1'b0;

    case (kind_e'(item_i.kind))
      KIND_READ: begin
        case (item_i.access_size)
          SIZE_BYTE: rdata = (item_i.offset == OFF_SOF) ? {24'd0, sof_q} : UNMAPPED_BYTE;
          SIZE_WORD: begin
            rdata = UNMAPPED_WORD;
            case (item_i.offset)
              OFF_CMD:   rdata = {16'd0, cmd_q};
              OFF_STS:   rdata = {26'd0, sts_q};
              OFF_INTR:  rdata = {16'd0, inten_q};
              OFF_FRNUM: rdata = {21'd0, frnum_q};
              default: begin
                for (int n = 0; n < PORT_COUNT; n++) begin
                  if (item_i.offset >= OFF_PORTSC && int'(item_i.offset[3:1]) == n) begin
                    rdata = {16'd0, pc_q[n]};
                  end
                end
              end
            endcase
          end
          default: rdata = (item_i.offset == OFF_FLBASE) ? {flbase_q, 12'd0} : UNMAPPED_LONG;
        endcase
      end

      KIND_WRITE: begin
        case (item_i.access_size)
          SIZE_BYTE: begin
            if (item_i.offset == OFF_SOF) sof_d = item_i.wdata[7:0];
          end
          SIZE_WORD: begin
            case (item_i.offset)
              OFF_CMD: begin
                if (val[CMD_RS] && !cmd_q[CMD_RS]) begin
                  running_d         = 1'b1;
                  sts_d[ST_HALTED]  = 1'b0;
                end else if (!val[CMD_RS]) begin
                  sts_d[ST_HALTED]  = 1'b1;
                end
                if (val[CMD_GRESET]) begin
                  for (int n = 0; n < PORT_COUNT; n++) rst_mask[n] = present_q[n];
                  creset = 1'b1;
                end else if (val[CMD_HCRESET]) begin
                  creset = 1'b1;
                end else begin
                  cmd_d = val;
                end
              end
              OFF_STS: begin
                sts_d = sts_q & ~val[5:0];
                if (val[ST_USBINT]) hint_d = '0;
                upd = 1'b1;
              end
              OFF_INTR: begin
                inten_d = val;
                upd     = 1'b1;
              end
              OFF_FRNUM: begin
                if (sts_q[ST_HALTED]) frnum_d = val[10:0];
              end
              default: begin
                for (int n = 0; n < PORT_COUNT; n++) begin
                  if (item_i.offset >= OFF_PORTSC && int'(item_i.offset[3:1]) == n) begin
                    if (present_q[n] && val[PC_RESET] && !pc_q[n][PC_RESET]) rst_mask[n] = 1'b1;
                    pc_d[n] = ((pc_q[n] & PC_KEEP_MASK) | (val & ~PC_KEEP_MASK)) &
                              ~(val & PC_W1C_MASK);
                  end
                end
              end
            endcase
          end
          default: begin
            if (item_i.offset == OFF_FLBASE) flbase_d = item_i.wdata[31:12];
          end
        endcase
      end

      KIND_TICK: begin
        if (running_q) begin
          if (!cmd_q[CMD_RS]) begin
            running_d        = 1'b0;
            sts_d[ST_HALTED] = 1'b1;
          end else begin
            if (item_i.frame_ints != 2'd0) begin
              hint_d           = hint_q | item_i.frame_ints;
              sts_d[ST_USBINT] = 1'b1;
              upd              = 1'b1;
            end
            frnum_d = frnum_q + 11'd1;
            fstart  = 1'b1;
            // frame index times four never carries past bit 11
            faddr   = {flbase_q, frnum_d[9:0], 2'b00};
          end
        end
      end

      KIND_ATTACH, KIND_DETACH: begin
        for (int n = 0; n < PORT_COUNT; n++) begin
          if (int'(item_i.port) == n) begin
            c = pc_q[n];
            // detach step: always on detach, on attach only over a present device
            if (kind_e'(item_i.kind) == KIND_DETACH || present_q[n]) begin
              if (c[PC_CCS]) begin
                c[PC_CCS] = 1'b0;
                c[PC_CSC] = 1'b1;
              end
              if (c[PC_EN]) begin
                c[PC_EN]  = 1'b0;
                c[PC_ENC] = 1'b1;
              end
            end
            if (kind_e'(item_i.kind) == KIND_ATTACH) begin
              c[PC_CCS]    = 1'b1;
              c[PC_CSC]    = 1'b1;
              c[PC_LSDA]   = item_i.low_speed;
              present_d[n] = 1'b1;
              low_d[n]     = item_i.low_speed;
              msg          = present_q[n] ? MSG_REATTACH : MSG_ATTACH;
            end else begin
              present_d[n] = 1'b0;
              msg          = present_q[n] ? MSG_DETACH : MSG_NONE;
            end
            pc_d[n] = c;
            // resume signaling while in global suspend
            if (cmd_q[CMD_EGSM]) begin
              cmd_d[CMD_FGR] = 1'b1;
              sts_d[ST_RD]   = 1'b1;
              upd            = 1'b1;
            end
          end
        end
      end

      KIND_ERROR: begin
        if (item_i.err_flags[0]) sts_d[ST_USBERR] = 1'b1;
        if (item_i.err_flags[1]) sts_d[ST_HCPERR] = 1'b1;
        upd = |item_i.err_flags;
      end

      default: ;
    endcase

    // controller reset keeps frame number, run flag, irq line and devices
    if (creset) begin
      cmd_d    = '0;
      sts_d    = '0;
      hint_d   = '0;
      inten_d  = '0;
      flbase_d = '0;
      sof_d    = SOF_RESET;
      for (int n = 0; n < PORT_COUNT; n++) begin
        pc_d[n] = PC_RESET_VAL;
        if (present_q[n]) begin
          pc_d[n][PC_CCS]  = 1'b1;
          pc_d[n][PC_CSC]  = 1'b1;
          pc_d[n][PC_LSDA] = low_q[n];
          msg              = MSG_REATTACH;
        end
      end
    end

    irq_d = upd ? irq_calc(hint_d, inten_d, sts_d) : irq_q;

    res_o.rdata       = rdata;
    res_o.irq_level   = irq_d;
    res_o.reset_ports = rst_mask[1:0];
    res_o.port_msg    = msg;
    res_o.frame_start = fstart;
    res_o.frame_ptr   = faddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= '0;
      sts_q     <= '0;
      hint_q    <= '0;
      inten_q   <= '0;
      frnum_q   <= '0;
      flbase_q  <= '0;
      sof_q     <= SOF_RESET;
      for (int n = 0; n < PORT_COUNT; n++) pc_q[n] <= PC_RESET_VAL;
      present_q <= '0;
      low_q     <= '0;
      running_q <= 1'b0;
      irq_q     <= 1'b0;
    end else if (fire_i) begin
      cmd_q     <= cmd_d;
      sts_q     <= sts_d;
      hint_q    <= hint_d;
      inten_q   <= inten_d;
      frnum_q   <= frnum_d;
      flbase_q  <= flbase_d;
      sof_q     <= sof_d;
      pc_q      <= pc_d;
      present_q <= present_d;
      low_q     <= low_d;
      running_q <= running_d;
      irq_q     <= irq_d;
    end
  end

endmodule

// ===== rtl/uhcr_out_reg.sv =====
// uhcr_out_reg: result register of the UHCI register file.
// Depends on uhcr_pkg and uhcr_out_if.
module uhcr_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  uhcr_pkg::result_t res_i,
  output logic              free_o,
  uhcr_out_if.source        out_o
);
  import uhcr_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.rdata       = res_q.rdata;
  assign out_o.irq_level   = res_q.irq_level;
  assign out_o.reset_ports = res_q.reset_ports;
  assign out_o.port_msg    = res_q.port_msg;
  assign out_o.frame_start = res_q.frame_start;
  assign out_o.frame_ptr   = res_q.frame_ptr;

endmodule

// ===== rtl/usb_host_controller_registers.sv =====
// usb_host_controller_registers: top level of the UHCI register file.
// Depends on uhcr_pkg, uhcr_if, uhcr_in_reg, uhcr_regfile and uhcr_out_reg.
//
// Usage:
//   in_i carries one transaction per handshake: a byte/word/long bus read or
//   write to the 32-byte io window, a frame tick, a root port attach or
//   detach, or an error report. out_o returns exactly one result per input
//   transaction, in order: read data, the interrupt line level, port bus
//   reset mask, attach/detach message and the frame-start address.
//   An accepted transaction waits in the input register until the result
//   register is free; the register file then updates and the result is
//   registered, and out_o.valid stays high until the result is taken.
//   Throughput: one transaction per cycle while out_o.ready is high, set by
//   the single-pass update from the input register to the result register.
//   Stall: while out_o.ready is low the result holds, the input register
//   keeps one more transaction, and in_i.ready drops once both are full.
//   Reset (rst_ni low, asynchronous): both stages empty, the architectural registers take
//   their power-on values (SOF timing 64, port control 0x0080, no devices).
//   PORT_COUNT (1 to 8) sets the number of root ports; ports at or above it
//   read as unmapped and ignore attach and detach.
module usb_host_controller_registers #(
  parameter int unsigned PORT_COUNT = uhcr_pkg::PORT_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uhcr_in_if.sink    in_i,
  uhcr_out_if.source out_o
);
  import uhcr_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    out_free;
  logic    fire;
  result_t res;

  // a transaction moves through the register file when the result slot is free
  assign fire = item_valid && out_free;

  uhcr_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (fire),
    .valid_o (item_valid),
    .item_o  (item)
  );

  uhcr_regfile #(
    .PORT_COUNT (PORT_COUNT)
  ) u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .res_o  (res)
  );

  uhcr_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

// ===== rtl/uhcr_checker.sv =====
// uhcr_checker: port-level assertions for the UHCI register file.
// Depends on the top level's ports only; bound to the top level below.
module uhcr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] rdata_i,
  input logic        irq_level_i,
  input logic [1:0]  reset_ports_i,
  input logic [1:0]  port_msg_i,
  input logic        frame_start_i,
  input logic [31:0] frame_ptr_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(rdata_i) &&
      $stable(irq_level_i) && $stable(reset_ports_i) && $stable(port_msg_i) &&
      $stable(frame_start_i) && $stable(frame_ptr_i))
    else $error("stalled result changed");

  // the result stage comes out of reset empty
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

  // every accepted transaction is followed by a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##2 out_valid_i)
    else $error("no result two cycles after acceptance");

  // a frame start comes from a tick: no read data, bus reset or port message, and a word-aligned frame address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_start_i |->
      rdata_i == 32'd0 && reset_ports_i == 2'd0 && port_msg_i == 2'd0 &&
      frame_ptr_i[1:0] == 2'd0)
    else $error("frame start mixed with other results");

  // frame address is only driven with a frame start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !frame_start_i |-> frame_ptr_i == 32'd0)
    else $error("frame address without frame start");

endmodule

bind usb_host_controller_registers uhcr_checker u_uhcr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .rdata_i       (out_o.rdata),
  .irq_level_i   (out_o.irq_level),
  .reset_ports_i (out_o.reset_ports),
  .port_msg_i    (out_o.port_msg),
  .frame_start_i (out_o.frame_start),
  .frame_ptr_i   (out_o.frame_ptr)
);
